>>> hw/rtl/wnws_pkg.sv
// shared types and constants of the windowed nearest waypoint search
// used by the front, queue and back modules and by the top level
package wnws_pkg;

  localparam int unsigned COORD_W          = 32;
  localparam int unsigned DIST_W           = 2 * COORD_W + 1;
  localparam int unsigned IDX_OUT_W        = 12;
  localparam int unsigned FUNC_W           = 2;
  localparam int unsigned MIN_READY_POINTS = 2;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  // function codes on the input stream
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BLOCK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_APPEND,
    CMD_BLOCK,
    CMD_QUERY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  x;
  } cmd_t;

  // packed so that nearest_index sits in the lowest bits
  typedef struct packed {
    logic                 store_full;
    logic                 near_end;
    logic                 path_ready;
    logic [IDX_OUT_W-1:0] nearest_index;
  } result_t;

endpackage

>>> hw/rtl/windowed_nearest_waypoint_search_top.sv
// top level of the windowed nearest waypoint search
// depends on wnws_pkg, wnws_front, wnws_queue and wnws_back
//
// usage:
//   the slave stream carries one command per transaction: tuser selects
//   start of a new path, append of a point, block of the path or a pose
//   query; tdata carries the coordinates as signed q16.16 metres
//   the master stream returns exactly one result per command, in order:
//   tracked nearest index, path ready, near end and store full
//   start, append and block, and a query on a finished path, pass through
//   the front register and the command queue to the result register
//   a live query scans its window at one point a cycle through the single
//   read port of the point store; its result is loaded once the window (up
//   to WINDOW_SPAN points) has run through the distance pipeline
//   a four-deep command queue lets the slave side keep accepting while a
//   scan runs or the result waits; when the receiver stalls the result
//   register holds its value and the queue fills, then tready drops
//   reset clears the point count and tracked index and marks the path as
//   finished; the point store holds no reset value and needs no clearing
module windowed_nearest_waypoint_search_top
  import wnws_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 4096,
  parameter int unsigned WINDOW_BACK = 200,
  parameter int unsigned WINDOW_SPAN = 400,
  parameter int unsigned END_MARGIN  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // coord_x [31:0], coord_y [63:32]
  input  logic [1:0]  s_axis_tuser,   // func [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // nearest_index [11:0], path_ready [12],
                                      // near_end [13], store_full [14], zero [15]
);

  // front to queue
  logic    fr_valid, fr_ready;
  cmd_t    fr_cmd;
  // queue to back
  logic    bk_valid, bk_ready;
  cmd_t    bk_cmd;
  // result
  result_t res;

  wnws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_x_i      (s_axis_tdata[31:0]),
    .in_y_i      (s_axis_tdata[63:32]),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  wnws_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_i       (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_o        (bk_cmd)
  );

  wnws_back #(
    .MAX_POINTS  (MAX_POINTS),
    .WINDOW_BACK (WINDOW_BACK),
    .WINDOW_SPAN (WINDOW_SPAN),
    .END_MARGIN  (END_MARGIN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // result fields packed from bit 0 up, top bit padding
  assign m_axis_tdata = {1'b0, res};

endmodule

>>> hw/rtl/wnws_front.sv
// front stage: accepts input transactions and classifies them into commands
// depends on wnws_pkg
module wnws_front
  import wnws_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [FUNC_W-1:0]         in_func_i,
  input  logic signed [COORD_W-1:0] in_x_i,
  input  logic signed [COORD_W-1:0] in_y_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_ready_i,
  output cmd_t                      cmd_o
);

  logic      hold_valid_q, hold_valid_d;
  cmd_t      cmd_q;
  cmd_kind_e kind;
  logic      take;

  always_comb begin
    unique case (in_func_i)
      FUNC_START:  kind = CMD_START;
      FUNC_APPEND: kind = CMD_APPEND;
      FUNC_BLOCK:  kind = CMD_BLOCK;
      FUNC_QUERY:  kind = CMD_QUERY;
      default:     kind = CMD_QUERY;
    endcase
  end

  assign in_ready_o = !hold_valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (take) begin
      hold_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q.kind <= kind;
      cmd_q.x    <= in_x_i;
      cmd_q.y    <= in_y_i;
    end
  end

  assign cmd_valid_o = hold_valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> hw/rtl/wnws_queue.sv
// short command queue between front and back
// depends on wnws_pkg
module wnws_queue
  import wnws_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

>>> hw/rtl/wnws_back.sv
// back stage: point store, path state, windowed scan pipeline, result register
// depends on wnws_pkg
module wnws_back
  import wnws_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 4096,
  parameter int unsigned WINDOW_BACK = 200,
  parameter int unsigned WINDOW_SPAN = 400,
  parameter int unsigned END_MARGIN  = 5
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  output logic    cmd_ready_o,
  input  cmd_t    cmd_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    =
    $clog2(MAX_POINTS + WINDOW_SPAN + WINDOW_BACK + END_MARGIN + 1);

  localparam logic [AW-1:0]    WB_A   = AW'(WINDOW_BACK);
  localparam logic [AW-1:0]    WS_A   = AW'(WINDOW_SPAN);
  localparam logic [AW-1:0]    EM_A   = AW'(END_MARGIN);
  localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] READY_C = CNT_W'(MIN_READY_POINTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // point store
  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];

  logic                      state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [IDX_W-1:0]          tracked_q, tracked_d;
  logic                      blocked_q, blocked_d;
  logic                      finished_q, finished_d;

  logic signed [COORD_W-1:0] pose_x_q, pose_y_q;
  logic [CNT_W-1:0]          scan_idx_q, scan_end_q;
  logic                      v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]          idx1_q, idx2_q, idx3_q, idx4_q;
  logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
  logic [COORD_W-1:0]        dx_q, dy_q;
  logic [2*COORD_W-1:0]      sx_q, sy_q;
  logic [DIST_W-1:0]         sum_q;
  logic                      have_q;
  logic [IDX_W-1:0]          best_idx_q;
  logic [DIST_W-1:0]         best_sum_q;

  logic                      out_valid_q;
  result_t                   out_q;

  logic                      out_free, pop, live_query, issue, drained, finish;
  logic                      we, load, near_end_d, full_d, ready_d;
  logic [IDX_W-1:0]          wa;
  logic [AW-1:0]             tr_a, cnt_a, start_a, end_a, best_a;
  logic [CNT_W-1:0]          win_start, win_end;
  logic [COORD_W:0]          diff_x, diff_y, mag_x, mag_y;
  logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
  result_t                   res_d;

  assign out_free    = !out_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign live_query  = (cmd_i.kind == CMD_QUERY) && !finished_q;
  assign issue       = (state_q == ST_SCAN) && (scan_idx_q < scan_end_q);
  assign drained     = (state_q == ST_SCAN) && !issue && !v1_q && !v2_q && !v3_q && !v4_q;
  assign finish      = drained && out_free;

  // window bounds from the tracked index
  always_comb begin
    tr_a    = AW'(tracked_q);
    cnt_a   = AW'(count_q);
    start_a = (tr_a > WB_A) ? tr_a - WB_A : '0;
    end_a   = start_a + WS_A;
    if (end_a > cnt_a) begin
      end_a = cnt_a;
    end
    win_start = start_a[CNT_W-1:0];
    win_end   = end_a[CNT_W-1:0];
  end

  assign best_a = AW'(best_idx_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    tracked_d  = tracked_q;
    blocked_d  = blocked_q;
    finished_d = finished_q;
    we         = 1'b0;
    wa         = '0;
    load       = 1'b0;
    near_end_d = 1'b0;
    full_d     = 1'b0;
    if (pop) begin
      unique case (cmd_i.kind)
        CMD_START: begin
          we         = 1'b1;
          count_d    = CNT_W'(1);
          tracked_d  = '0;
          blocked_d  = 1'b0;
          finished_d = 1'b0;
          load       = 1'b1;
        end
        CMD_APPEND: begin
          if (count_q < MAX_C) begin
            we      = 1'b1;
            wa      = count_q[IDX_W-1:0];
            count_d = count_q + 1'b1;
          end else begin
            full_d = 1'b1;
          end
          load = 1'b1;
        end
        CMD_BLOCK: begin
          blocked_d = 1'b1;
          load      = 1'b1;
        end
        CMD_QUERY: begin
          if (live_query) begin
            state_d = ST_SCAN;
          end else begin
            load = 1'b1;
          end
        end
      endcase
    end
    if (finish) begin
      tracked_d = best_idx_q;
      // end test only on a ready path
      if ((count_q >= READY_C) && !blocked_q && !finished_q && (best_a + EM_A >= cnt_a)) begin
        near_end_d = 1'b1;
        finished_d = 1'b1;
      end
      load    = 1'b1;
      state_d = ST_IDLE;
    end
    ready_d = (count_d >= READY_C) && !blocked_d && !finished_d;
    idx_ext = (IDX_W + IDX_OUT_W)'(tracked_d);
    res_d.nearest_index = idx_ext[IDX_OUT_W-1:0];
    res_d.path_ready    = ready_d;
    res_d.near_end      = near_end_d;
    res_d.store_full    = full_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      tracked_q   <= '0;
      blocked_q   <= 1'b0;
      finished_q  <= 1'b1;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      have_q      <= 1'b0;
      scan_idx_q  <= '0;
      scan_end_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      tracked_q  <= tracked_d;
      blocked_q  <= blocked_d;
      finished_q <= finished_d;
      v1_q       <= issue;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      if (pop && live_query) begin
        scan_idx_q <= win_start;
        scan_end_q <= win_end;
        have_q     <= 1'b0;
      end else begin
        if (issue) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (v4_q && (!have_q || (sum_q < best_sum_q))) begin
          have_q <= 1'b1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_x[wa] <= cmd_i.x;
    end
    rd_x_q <= mem_x[scan_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_y[wa] <= cmd_i.y;
    end
    rd_y_q <= mem_y[scan_idx_q[IDX_W-1:0]];
  end

  // distance pipeline: difference, squares, sum
  always_comb begin
    diff_x = {rd_x_q[COORD_W-1], rd_x_q} - {pose_x_q[COORD_W-1], pose_x_q};
    diff_y = {rd_y_q[COORD_W-1], rd_y_q} - {pose_y_q[COORD_W-1], pose_y_q};
    mag_x  = diff_x[COORD_W] ? -diff_x : diff_x;
    mag_y  = diff_y[COORD_W] ? -diff_y : diff_y;
  end

  always_ff @(posedge clk_i) begin
    if (pop && live_query) begin
      pose_x_q   <= cmd_i.x;
      pose_y_q   <= cmd_i.y;
      best_idx_q <= '0;
    end else if (v4_q && (!have_q || (sum_q < best_sum_q))) begin
      best_idx_q <= idx4_q;
      best_sum_q <= sum_q;
    end
    idx1_q <= scan_idx_q[IDX_W-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    dx_q   <= mag_x[COORD_W-1:0];
    dy_q   <= mag_y[COORD_W-1:0];
    sx_q   <= dx_q * dx_q;
    sy_q   <= dy_q * dy_q;
    sum_q  <= {1'b0, sx_q} + {1'b0, sy_q};
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

>>> hw/rtl/wnws_checker.sv
// port-level checks of the windowed nearest waypoint search
// bound to windowed_nearest_waypoint_search_top, no other dependencies
module wnws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a query that finishes the path leaves it not ready
  a_end_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[12])
    else $error("near end reported on a ready path");

  // near end comes from queries only, store full from appends only, top bit zero
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[13] && m_axis_tdata[14]) && !m_axis_tdata[15])
    else $error("near end and store full in one result");

  // a dropped append on a ready path never reports near end
  a_full_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] && m_axis_tdata[12] |-> !m_axis_tdata[13])
    else $error("inconsistent flags on a dropped append");

endmodule

bind windowed_nearest_waypoint_search_top wnws_checker u_checker (.*);

>>> bench/waypoint_search_checker.sv
`timescale 1ns / 1ps
// checker for the windowed nearest waypoint search: watches both streams,
// predicts every result and compares it field by field
// depends on wnws_pkg for the function codes and the result layout
module waypoint_search_checker
  import wnws_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 4096,
  parameter int unsigned WINDOW_BACK = 200,
  parameter int unsigned WINDOW_SPAN = 400,
  parameter int unsigned END_MARGIN  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [63:0] cmd_data_i,   // coord_x [31:0], coord_y [63:32]
  input  logic [1:0]  cmd_func_i,   // func [1:0]
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [15:0] res_data_i,   // nearest_index [11:0], path_ready [12],
                                    // near_end [13], store_full [14]
  output int          mismatch_count_o,
  output int          outstanding_o,
  output int          commands_o,
  output int          queries_o,
  output int          finishes_o,
  output int          drops_o,
  output int          top_index_o
);

  // own copy of the path store and tracking state
  logic signed [COORD_W-1:0] way_x [MAX_POINTS];
  logic signed [COORD_W-1:0] way_y [MAX_POINTS];
  int unsigned n_points;
  int unsigned track_idx;
  bit          blocked;
  bit          finished;

  result_t     wanted_q [$];
  int          mismatches;
  int          results_seen;
  int          commands;
  int          queries;
  int          finishes;
  int          drops;
  int          top_index;

  function automatic logic [DIST_W-1:0] dist_sq(input logic signed [COORD_W-1:0] ax,
                                                input logic signed [COORD_W-1:0] ay,
                                                input logic signed [COORD_W-1:0] bx,
                                                input logic signed [COORD_W-1:0] by);
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        mx;
    logic [COORD_W:0]        my;
    logic [DIST_W-1:0]       sx;
    logic [DIST_W-1:0]       sy;
    dx = ax - bx;
    dy = ay - by;
    mx = dx[COORD_W] ? -dx : dx;
    my = dy[COORD_W] ? -dy : dy;
    sx = mx * mx;
    sy = my * my;
    return sx + sy;
  endfunction

  function automatic bit path_is_ready();
    return n_points >= MIN_READY_POINTS && !blocked && !finished;
  endfunction

  // applies one command to the tracking state and returns its result
  function automatic result_t apply_command(input logic [FUNC_W-1:0]      func,
                                            input logic signed [COORD_W-1:0] px,
                                            input logic signed [COORD_W-1:0] py);
    result_t           res;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       best;
    int unsigned       i;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] best_d;
    bit                found;
    res = '0;
    case (func)
      FUNC_START: begin
        way_x[0]  = px;
        way_y[0]  = py;
        n_points  = 1;
        track_idx = 0;
        blocked   = 1'b0;
        finished  = 1'b0;
      end
      FUNC_APPEND: begin
        if (n_points < MAX_POINTS) begin
          way_x[n_points] = px;
          way_y[n_points] = py;
          n_points++;
        end else begin
          res.store_full = 1'b1;
        end
      end
      FUNC_BLOCK: begin
        blocked = 1'b1;
      end
      FUNC_QUERY: begin
        // no scan at all once the path is done or before the first start
        if (!finished) begin
          lo = (track_idx > WINDOW_BACK) ? track_idx - WINDOW_BACK : 0;
          hi = lo + WINDOW_SPAN;
          if (hi > n_points) hi = n_points;
          best   = 0;
          best_d = '0;
          found  = 1'b0;
          for (i = lo; i < hi; i++) begin
            d = dist_sq(way_x[i], way_y[i], px, py);
            // strict compare keeps the lowest index on a tie
            if (!found || d < best_d) begin
              found  = 1'b1;
              best   = i;
              best_d = d;
            end
          end
          track_idx = best;
          if (path_is_ready() && track_idx + END_MARGIN >= n_points) begin
            res.near_end = 1'b1;
            finished     = 1'b1;
          end
        end
      end
    endcase
    res.nearest_index = track_idx[IDX_OUT_W-1:0];
    res.path_ready    = path_is_ready();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d: %s is %0d, should be %0d", $realtime, results_seen, what,
             got, want);
    mismatches++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (wanted_q.size() == 0) begin
      report_mismatch("result with no command outstanding", int'(got), 0);
    end else begin
      want = wanted_q.pop_front();
      if (got.nearest_index != want.nearest_index)
        report_mismatch("nearest_index", int'(got.nearest_index),
                        int'(want.nearest_index));
      if (got.path_ready != want.path_ready)
        report_mismatch("path_ready", int'(got.path_ready), int'(want.path_ready));
      if (got.near_end != want.near_end)
        report_mismatch("near_end", int'(got.near_end), int'(want.near_end));
      if (got.store_full != want.store_full)
        report_mismatch("store_full", int'(got.store_full), int'(want.store_full));
    end
    if (got.near_end) finishes++;
    if (got.store_full) drops++;
    if (int'(got.nearest_index) > top_index) top_index = int'(got.nearest_index);
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_points  = 0;
      track_idx = 0;
      blocked   = 1'b0;
      finished  = 1'b1;
      wanted_q.delete();
      mismatches   = 0;
      results_seen = 0;
      commands     = 0;
      queries      = 0;
      finishes     = 0;
      drops        = 0;
      top_index    = 0;
    end else begin
      if (res_valid_i && res_ready_i)
        check_result(result_t'(res_data_i[$bits(result_t)-1:0]));
      if (cmd_valid_i && cmd_ready_i) begin
        wanted_q.insert(wanted_q.size(),
                        apply_command(cmd_func_i, cmd_data_i[31:0], cmd_data_i[63:32]));
        commands++;
        if (cmd_func_i == FUNC_QUERY) queries++;
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= wanted_q.size();
    commands_o       <= commands;
    queries_o        <= queries;
    finishes_o       <= finishes;
    drops_o          <= drops;
    top_index_o      <= top_index;
  end

endmodule

>>> bench/windowed_nearest_waypoint_search_top_test.sv
`timescale 1ns / 1ps
// testbench top for the windowed nearest waypoint search: drives commands,
// throttles the result stream and gives the verdict
// depends on wnws_pkg, the block under test and waypoint_search_checker
module windowed_nearest_waypoint_search_top_test;
  import wnws_pkg::*;

  localparam int unsigned MAX_POINTS   = 4096;
  localparam int unsigned WINDOW_BACK  = 200;
  localparam int unsigned WINDOW_SPAN  = 400;
  localparam int unsigned END_MARGIN   = 5;

  localparam int          METRE        = 1 << 16;   // one metre in q16.16
  localparam int          COORD_MIN    = 32'h8000_0000;
  localparam int          COORD_MAX    = 32'h7FFF_FFFF;
  localparam int          RANDOM_ITEMS = 1090;
  localparam int          HOLD_CYCLES  = 300;
  // a live query scans up to a full window; allow margin
  localparam int          DRAIN_CYCLES = WINDOW_SPAN + 50;
  // slowest correct run: about 1200 transactions, each a full window scan
  // behind a stalled receiver, sets this limit
  localparam int          CYCLE_LIMIT  = 3_000_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;        // coord_x [31:0], coord_y [63:32]
  logic [1:0]  s_axis_tuser  = FUNC_START; // func [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;              // nearest_index [11:0], path_ready [12],
                                          // near_end [13], store_full [14]

  // receiver control: a request counter asks for a long hold-off, steady
  // switches random idling off on both sides
  int          holds_asked  = 0;
  int          holds_served = 0;
  int          hold_left    = 0;
  logic        steady       = 1'b0;

  int          items_sent   = 0;
  int          cycles       = 0;

  int          mismatches;
  int          outstanding;
  int          commands;
  int          queries;
  int          finishes;
  int          drops;
  int          top_index;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  windowed_nearest_waypoint_search_top #(
    .MAX_POINTS  (MAX_POINTS),
    .WINDOW_BACK (WINDOW_BACK),
    .WINDOW_SPAN (WINDOW_SPAN),
    .END_MARGIN  (END_MARGIN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  waypoint_search_checker #(
    .MAX_POINTS  (MAX_POINTS),
    .WINDOW_BACK (WINDOW_BACK),
    .WINDOW_SPAN (WINDOW_SPAN),
    .END_MARGIN  (END_MARGIN)
  ) checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (s_axis_tvalid),
    .cmd_ready_i      (s_axis_tready),
    .cmd_data_i       (s_axis_tdata),
    .cmd_func_i       (s_axis_tuser),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .commands_o       (commands),
    .queries_o        (queries),
    .finishes_o       (finishes),
    .drops_o          (drops),
    .top_index_o      (top_index)
  );

  // receiver side: random stalls, or a counted hold-off when one is asked for
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served  <= holds_asked;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 10);
    end
  end

  // watchdog against a hung block
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // offers one command and returns at the edge where the transaction happens
  task automatic send_item(input logic [FUNC_W-1:0] func, input int x, input int y);
    while (!steady && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // sender pause: nothing offered until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // extremes of the coordinates, ties, blocked and short paths, queries
  // before any start and after the path is finished
  task automatic run_directed();
    int i;
    send_item(FUNC_QUERY, 0, 0);                       // no path yet
    send_item(FUNC_APPEND, 5 * METRE, 5 * METRE);      // append without a start
    send_item(FUNC_QUERY, 5 * METRE, 5 * METRE);
    send_item(FUNC_START, COORD_MIN, COORD_MIN);
    send_item(FUNC_APPEND, COORD_MAX, COORD_MAX);
    send_item(FUNC_BLOCK, 0, 0);
    send_item(FUNC_QUERY, COORD_MAX, COORD_MAX);       // blocked: scans, never finishes
    send_item(FUNC_APPEND, COORD_MIN, COORD_MAX);
    send_item(FUNC_QUERY, COORD_MIN, COORD_MAX);
    send_item(FUNC_START, COORD_MIN, COORD_MIN);       // clears the block
    send_item(FUNC_APPEND, COORD_MAX, COORD_MAX);
    send_item(FUNC_APPEND, COORD_MAX, COORD_MIN);
    // first two points tie, the third needs the 65th distance bit,
    // and the three-point path finishes on this first ready query
    send_item(FUNC_QUERY, COORD_MIN, COORD_MAX);
    send_item(FUNC_QUERY, 0, 0);                       // finished: index kept
    send_item(FUNC_APPEND, 0, 0);                      // append after finish
    send_item(FUNC_START, 0, 0);
    for (i = 1; i < 8; i++)
      send_item(FUNC_APPEND, (i == 3 ? 2 : i) * METRE, 0);  // points 2 and 3 coincide
    send_item(FUNC_QUERY, 2 * METRE, 0);               // tie goes to the lower index
    send_item(FUNC_QUERY, 7 * METRE, 0);               // reaches the end margin
  endtask

  // a well-formed path along a noisy line, then queries walking along it
  task automatic run_path(input int n_pts, input int step_bits);
    int path_x [$];
    int path_y [$];
    int base_x;
    int base_y;
    int step_x;
    int step_y;
    int spread;
    int block_at;
    int cursor;
    int target;
    int i;
    base_x   = $signed($urandom) >>> 2;
    base_y   = $signed($urandom) >>> 2;
    step_x   = int'($urandom_range(1 << step_bits, 16));
    step_y   = int'($urandom_range(1 << step_bits)) - (1 << (step_bits - 1));
    spread   = 1 << (step_bits - 3);
    if ($urandom_range(1)) step_x = -step_x;
    block_at = ($urandom_range(99) < 10) ? int'($urandom_range(n_pts)) : -1;
    for (i = 0; i < n_pts; i++) begin
      path_x.insert(path_x.size(), base_x + i * step_x + int'($urandom_range(15)) - 8);
      path_y.insert(path_y.size(), base_y + i * step_y + int'($urandom_range(15)) - 8);
    end
    send_item(FUNC_START, path_x[0], path_y[0]);
    for (i = 1; i < n_pts; i++) begin
      if (i == block_at) send_item(FUNC_BLOCK, $urandom, $urandom);
      send_item(FUNC_APPEND, path_x[i], path_y[i]);
    end
    cursor = 0;
    while (cursor < n_pts - 1) begin
      cursor += $urandom_range(n_pts / 8 + 1, 1);
      if (cursor > n_pts - 1) cursor = n_pts - 1;
      target = cursor + int'($urandom_range(6)) - 3;
      if (target < 0) target = 0;
      if (target > n_pts - 1) target = n_pts - 1;
      send_item(FUNC_QUERY,
                path_x[target] + int'($urandom_range(2 * spread)) - spread,
                path_y[target] + int'($urandom_range(2 * spread)) - spread);
      // now and then the path grows or gets blocked while being followed
      if ($urandom_range(99) < 4) begin
        path_x.insert(path_x.size(), path_x[n_pts - 1] + step_x);
        path_y.insert(path_y.size(), path_y[n_pts - 1] + step_y);
        send_item(FUNC_APPEND, path_x[n_pts], path_y[n_pts]);
        n_pts++;
      end
      if ($urandom_range(99) < 2) send_item(FUNC_BLOCK, 0, 0);
    end
    if ($urandom_range(99) < 30) begin
      target = $urandom_range(n_pts - 1);
      send_item(FUNC_QUERY, path_x[target], path_y[target]);
    end
  endtask

  // raw commands with full-range coordinates, broken sequences included
  task automatic run_noise();
    int n;
    int i;
    n = $urandom_range(8, 1);
    for (i = 0; i < n; i++)
      send_item(FUNC_W'($urandom_range(3)), $urandom, $urandom);
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    int first;
    int pick;
    int len;
    int bits;
    int left;
    first   = items_sent;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      // one stretch with no idling on either side
      steady <= (items_sent - first >= 450) && (items_sent - first < 600);
      pick = $urandom_range(99);
      if (pick < 74) begin
        if (pick < 70) begin
          len  = int'($urandom_range(40, 2));
          bits = int'($urandom_range(20, 10));
        end else begin
          len  = int'($urandom_range(300, 100));
          bits = int'($urandom_range(14, 10));
        end
        // keep the last path within the remaining budget
        left = stop_at - items_sent;
        if (len > left) len = (left > 2) ? left : 2;
        run_path(len, bits);
      end else begin
        run_noise();
      end
    end
    steady <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    // receiver holds off while commands keep coming, so the command queue
    // fills and tready drops
    holds_asked <= holds_asked + 1;
    run_path(24, 16);
    drain();

    run_random(RANDOM_ITEMS);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands checked, %0d of them pose queries; %0d paths reached the end",
             commands, queries, finishes);
    $display("%0d appends dropped on a full store, highest nearest index %0d",
             drops, top_index);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
